FILE: src/uvs_pkg.sv
// Shared types and constants for the UV sphere cell tessellator.
`default_nettype none
package uvs_pkg;

  localparam int CordicW = 34;
  localparam logic signed [CordicW-1:0] CordicGain = 34'sd652032874;
  localparam logic signed [CordicW-1:0] OneQ30 = 34'sd1073741824;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_RADIUS = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_WIDTH  = 2'd2;

  typedef struct packed {
    logic [15:0] radius;
    logic [8:0]  height_segments;
    logic [8:0]  width_segments;
  } uvs_cfg_t;

  typedef struct packed {
    logic        start_dir;
    logic [8:0]  k;
    logic [8:0]  j;
    logic        pole;
    logic        pole_top;
    logic        start_emit;
    logic        emit_vertex;
    logic [1:0]  slot;
  } uvs_cmd_t;

  typedef struct packed {
    logic dir_done;
    logic emit_done;
  } uvs_sts_t;

  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] t;
    begin
      case (i)
        5'd0: t = 32'h20000000; 5'd1: t = 32'h12E4051D; 5'd2: t = 32'h09FB385B;
        5'd3: t = 32'h051111D4; 5'd4: t = 32'h028B0D43; 5'd5: t = 32'h0145D7E1;
        5'd6: t = 32'h00A2F61E; 5'd7: t = 32'h00517C55; 5'd8: t = 32'h0028BE53;
        5'd9: t = 32'h00145F2E; 5'd10: t = 32'h000A2F98; 5'd11: t = 32'h000517CC;
        5'd12: t = 32'h00028BE6; 5'd13: t = 32'h000145F3; 5'd14: t = 32'h0000A2F9;
        5'd15: t = 32'h0000517C; 5'd16: t = 32'h000028BE; 5'd17: t = 32'h0000145F;
        5'd18: t = 32'h00000A2F; 5'd19: t = 32'h00000517; 5'd20: t = 32'h0000028B;
        5'd21: t = 32'h00000145; 5'd22: t = 32'h000000A2; 5'd23: t = 32'h00000051;
        default: t = 32'h0;
      endcase
      return t;
    end
  endfunction

endpackage
`default_nettype wire

FILE: src/uvs_if.sv
// Valid/ready channel interfaces for the tessellator.
`default_nettype none
interface uvs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ring;
  logic [7:0] sector;
  logic       restart;
  modport source (output valid, ring, sector, restart, input ready);
  modport sink (input valid, ring, sector, restart, output ready);
endinterface

interface uvs_out_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic signed [16:0] pos_x;
  logic signed [16:0] pos_y;
  logic signed [16:0] pos_z;
  logic signed [15:0] norm_x;
  logic signed [15:0] norm_y;
  logic signed [15:0] norm_z;
  logic [17:0]        vertex_index;
  logic               last;
  modport source (output valid, kind, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                  vertex_index, last, input ready);
  modport sink (input valid, kind, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                vertex_index, last, output ready);
endinterface

interface uvs_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: src/uvs_divider.sv
// Restoring divider for the angle fractions, one quotient bit per cycle.
`default_nettype none
module uvs_divider (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [40:0] dividend,
  input  wire logic [8:0]  divisor,
  output logic             done,
  output logic [40:0]      quotient
);
  logic [40:0] q_r, q_nxt;
  logic [9:0]  rem_r, rem_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [9:0]  trial;

  assign done = done_r;
  assign quotient = q_r;

  always_comb begin
    q_nxt = q_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial = {rem_r[8:0], q_r[40]};
    if (start) begin
      q_nxt = dividend;
      rem_nxt = '0;
      cnt_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = trial - {1'b0, divisor};
        q_nxt = {q_r[39:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt = {q_r[39:0], 1'b0};
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd40) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
  end
endmodule
`default_nettype wire

FILE: src/uvs_datapath.sv
// Datapath: angle division, shared CORDIC, direction products and output formatting.
`default_nettype none
module uvs_datapath #(
  parameter int TRIG_ITERATIONS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire uvs_pkg::uvs_cfg_t    cfg,
  input  wire uvs_pkg::uvs_cmd_t    cmd,
  input  wire logic [18:0]          vbase,
  output uvs_pkg::uvs_sts_t         sts,
  output logic signed [16:0]        pos_x,
  output logic signed [16:0]        pos_y,
  output logic signed [16:0]        pos_z,
  output logic signed [15:0]        norm_x,
  output logic signed [15:0]        norm_y,
  output logic signed [15:0]        norm_z,
  output logic [17:0]               vidx
);
  import uvs_pkg::*;

  localparam int Iters = (TRIG_ITERATIONS > 24) ? 24 : TRIG_ITERATIONS;

  typedef enum logic [9:0] {
    D_IDLE  = 10'b0000000001,
    D_DIVT  = 10'b0000000010,
    D_DIVP  = 10'b0000000100,
    D_CORT  = 10'b0000001000,
    D_CORP  = 10'b0000010000,
    D_MUL   = 10'b0000100000,
    D_RND   = 10'b0001000000,
    D_EMUL  = 10'b0010000000,
    D_ERND  = 10'b0100000000,
    D_WAIT  = 10'b1000000000
  } dstate_t;

  dstate_t st_r, st_nxt;

  // Direction store, one row per vertex slot.
  logic signed [CordicW-1:0] dir_r [4][3];
  logic [8:0]  j_r;
  logic [1:0]  slot_r;
  logic [31:0] th_r, ph_r;

  // Divider.
  logic        div_start, div_done;
  logic [40:0] div_dvd, div_q;
  logic [8:0]  div_dvs;
  uvs_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_dvd),
    .divisor(div_dvs), .done(div_done), .quotient(div_q)
  );

  // CORDIC registers.
  logic signed [CordicW-1:0] cx_r, cy_r, cz_r;
  logic [4:0] ci_r;
  logic       cflip_r;
  logic signed [CordicW-1:0] st_v_r, ct_v_r;
  logic signed [CordicW-1:0] dx, dy, atn;
  logic [31:0] ang;
  logic        flip_a;
  logic [31:0] ang_red;

  // Products.
  logic signed [67:0] p0_r, p1_r;
  logic signed [CordicW-1:0] dc;
  logic [1:0]  ec_r;
  logic signed [50:0] pr_r;

  function automatic logic signed [CordicW-1:0] rnd30(input logic signed [67:0] v);
    logic signed [67:0] t;
    begin
      t = v + 68'sd536870912;
      return CordicW'(t >>> 30);
    end
  endfunction

  assign dx = cy_r >>> ci_r;
  assign dy = cx_r >>> ci_r;
  assign atn = CordicW'({2'b00, atan_turn(ci_r)});
  assign flip_a = (ang - 32'h40000000) < 32'h80000000;
  assign ang_red = flip_a ? ang - 32'h80000000 : ang;
  // Theta is loaded while the phi division finishes, phi at the end of the theta pass.
  assign ang = (st_r == D_DIVP) ? th_r : ph_r;

  always_comb begin
    st_nxt = st_r;
    div_start = 1'b0;
    div_dvd = '0;
    div_dvs = cfg.height_segments;
    unique case (st_r)
      D_IDLE: begin
        if (cmd.start_dir) begin
          div_start = 1'b1;
          div_dvd = {cmd.k, 32'h0} >> 1;
          st_nxt = D_DIVT;
        end else if (cmd.start_emit) begin
          st_nxt = cmd.emit_vertex ? D_EMUL : D_WAIT;
        end
      end
      D_DIVT: if (div_done) begin
        div_start = 1'b1;
        div_dvd = {j_r, 32'h0};
        div_dvs = cfg.width_segments;
        st_nxt = D_DIVP;
      end
      D_DIVP: begin
        div_dvs = cfg.width_segments;
        if (div_done) st_nxt = D_CORT;
      end
      D_CORT: if (ci_r == 5'(Iters)) st_nxt = D_CORP;
      D_CORP: if (ci_r == 5'(Iters)) st_nxt = D_MUL;
      D_MUL:  st_nxt = D_RND;
      D_RND:  st_nxt = D_IDLE;
      D_EMUL: st_nxt = D_ERND;
      D_ERND: if (ec_r == 2'd2) st_nxt = D_WAIT; else st_nxt = D_EMUL;
      D_WAIT: st_nxt = D_IDLE;
      default: st_nxt = D_IDLE;
    endcase
  end

  // The direction is reported while the last step retires, so the controller's
  // next command meets an idle datapath.
  assign sts.dir_done = (st_r == D_RND);
  assign sts.emit_done = (st_r == D_WAIT);

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= D_IDLE;
    else st_r <= st_nxt;
  end

  // Pole rows are written directly.
  logic signed [CordicW-1:0] comp;
  logic signed [49:0] pos_w;
  logic signed [CordicW-1:0] nrm_w;
  assign comp = dir_r[slot_r][ec_r];
  assign dc = comp;

  // Rounded and clamped position and normal of the component being emitted.
  always_comb begin
    pos_w = 50'((pr_r + 51'sd536870912) >>> 30);
    nrm_w = (dc + 34'sd32768) >>> 16;
    if (pos_w > 50'sd65535) pos_w = 50'sd65535;
    else if (pos_w < -50'sd65535) pos_w = -50'sd65535;
    if (nrm_w > 34'sd16384) nrm_w = 34'sd16384;
    else if (nrm_w < -34'sd16384) nrm_w = -34'sd16384;
  end

  always_ff @(posedge clk) begin
    if (st_r == D_IDLE && cmd.start_dir) begin
      j_r <= cmd.j;
      slot_r <= cmd.slot;
    end
    if (st_r == D_IDLE && cmd.pole) begin
      dir_r[0][0] <= '0;
      dir_r[0][1] <= cmd.pole_top ? OneQ30 : -OneQ30;
      dir_r[0][2] <= '0;
    end
    if (st_r == D_IDLE && cmd.start_emit) begin
      slot_r <= cmd.slot;
      ec_r <= '0;
      vidx <= 18'(vbase + {17'b0, cmd.slot});
      pos_x <= '0; pos_y <= '0; pos_z <= '0;
      norm_x <= '0; norm_y <= '0; norm_z <= '0;
    end
    if (st_r == D_DIVT && div_done) th_r <= div_q[31:0];
    if (st_r == D_DIVP && div_done) begin
      ph_r <= div_q[31:0];
    end
    // CORDIC start when entering each pass.
    if ((st_r == D_DIVP && div_done) || (st_r == D_CORT && ci_r == 5'(Iters))) begin
      ci_r <= '0;
      cx_r <= CordicGain;
      cy_r <= '0;
    end
    if (st_r == D_CORT || st_r == D_CORP) begin
      if (ci_r != 5'(Iters)) begin
        if (!cz_r[CordicW-1]) begin
          cx_r <= cx_r - dx; cy_r <= cy_r + dy; cz_r <= cz_r - atn;
        end else begin
          cx_r <= cx_r + dx; cy_r <= cy_r - dy; cz_r <= cz_r + atn;
        end
        ci_r <= ci_r + 5'd1;
      end
    end
    // Angle load: z from the reduced angle, flip noted.
    if (st_r == D_DIVP && div_done) begin
      cz_r <= CordicW'($signed(ang_red));
      cflip_r <= flip_a;
    end
    if (st_r == D_CORT && ci_r == 5'(Iters)) begin
      st_v_r <= cflip_r ? -cy_r : cy_r;
      ct_v_r <= cflip_r ? -cx_r : cx_r;
      cz_r <= CordicW'($signed(ang_red));
      cflip_r <= flip_a;
    end
    if (st_r == D_CORP && ci_r == 5'(Iters)) begin
      p0_r <= 68'(st_v_r) * 68'(cflip_r ? -cy_r : cy_r);
      p1_r <= 68'(st_v_r) * 68'(cflip_r ? -cx_r : cx_r);
    end
    if (st_r == D_MUL) begin
      dir_r[slot_r][0] <= rnd30(p0_r);
      dir_r[slot_r][1] <= ct_v_r;
      dir_r[slot_r][2] <= rnd30(p1_r);
    end
    if (st_r == D_EMUL) pr_r <= 51'($signed({1'b0, cfg.radius})) * 51'(dc);
    if (st_r == D_ERND) begin
      case (ec_r)
        2'd0: begin pos_x <= pos_w[16:0]; norm_x <= nrm_w[15:0]; end
        2'd1: begin pos_y <= pos_w[16:0]; norm_y <= nrm_w[15:0]; end
        default: begin pos_z <= pos_w[16:0]; norm_z <= nrm_w[15:0]; end
      endcase
      ec_r <= ec_r + 2'd1;
    end
  end
endmodule
`default_nettype wire

FILE: src/uvs_control.sv
// Controller: walks the vertices and triangle indices of one cell.
`default_nettype none
module uvs_control #(
  parameter int MAX_SEGMENTS = 256
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire uvs_pkg::uvs_cfg_t cfg,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [7:0]        ring,
  input  wire logic [7:0]        sector,
  input  wire logic              restart,
  output uvs_pkg::uvs_cmd_t      cmd,
  input  wire uvs_pkg::uvs_sts_t sts,
  output logic [18:0]            vbase,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   kind,
  output logic                   last,
  output logic [17:0]            tri_index
);
  import uvs_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DIR  = 6'b000010,
    S_DWT  = 6'b000100,
    S_EMV  = 6'b001000,
    S_OUT  = 6'b010000,
    S_TRI  = 6'b100000
  } state_t;

  state_t     st_r, st_nxt;
  logic [18:0] base_r, base_nxt;
  logic [8:0]  ring_r, sec_r;
  logic        cap_r, top_r;
  logic [1:0]  vi_r, vi_nxt;
  logic [2:0]  ti_r, ti_nxt;
  logic        bad;

  assign vbase = base_r;
  assign in_ready = (st_r == S_IDLE);
  assign bad = (cfg.height_segments < 9'd2) || (cfg.width_segments < 9'd3) ||
               (32'(cfg.height_segments) > MAX_SEGMENTS) ||
               (32'(cfg.width_segments) > MAX_SEGMENTS) ||
               ({1'b0, ring} >= cfg.height_segments) ||
               ({1'b0, sector} >= cfg.width_segments);

  // Point of vertex vi for the current cell.
  always_comb begin
    cmd = '0;
    cmd.slot = vi_r;
    if (cap_r) begin
      cmd.k = top_r ? 9'd1 : ring_r;
      cmd.j = ((vi_r == 2'd2) == top_r) ? sec_r + 9'd1 : sec_r;
    end else begin
      cmd.k = (vi_r == 2'd1 || vi_r == 2'd2) ? ring_r + 9'd1 : ring_r;
      cmd.j = (vi_r == 2'd2 || vi_r == 2'd3) ? sec_r + 9'd1 : sec_r;
    end
    cmd.pole = (st_r == S_DIR) && cap_r && (vi_r == 2'd0);
    cmd.pole_top = top_r;
    cmd.start_dir = (st_r == S_DIR) && !(cap_r && vi_r == 2'd0);
    cmd.start_emit = (st_r == S_EMV);
    cmd.emit_vertex = 1'b1;
  end

  logic [2:0] tri_off;
  always_comb begin
    case (ti_r) inside
      3'd0, 3'd5: tri_off = 3'd0;
      3'd1: tri_off = 3'd1;
      3'd4: tri_off = 3'd3;
      default: tri_off = 3'd2;
    endcase
  end

  logic [2:0] nv, nt;
  assign nv = cap_r ? 3'd3 : 3'd4;
  assign nt = cap_r ? 3'd3 : 3'd6;

  logic tri_phase_r;
  assign tri_index = 18'(base_r + {16'b0, tri_off});
  assign kind = tri_phase_r;
  assign out_valid = (st_r == S_OUT) || (st_r == S_TRI);
  assign last = (st_r == S_TRI) && (ti_r == nt - 3'd1);

  always_comb begin
    st_nxt = st_r;
    base_nxt = base_r;
    vi_nxt = vi_r;
    ti_nxt = ti_r;
    unique case (st_r)
      S_IDLE: if (in_valid) begin
        if (restart) base_nxt = '0;
        vi_nxt = '0;
        ti_nxt = '0;
        if (!bad) st_nxt = S_DIR;
      end
      // The pole row is written straight from the command; the cap's ring points follow.
      S_DIR: if (cap_r && vi_r == 2'd0) begin
        vi_nxt = 2'd1;
        st_nxt = S_DIR;
      end else begin
        st_nxt = S_DWT;
      end
      S_DWT: if (sts.dir_done) begin
        if ({1'b0, vi_r} == nv - 3'd1) begin
          vi_nxt = '0;
          st_nxt = S_EMV;
        end else begin
          vi_nxt = vi_r + 2'd1;
          st_nxt = S_DIR;
        end
      end
      S_EMV: if (sts.emit_done) st_nxt = S_OUT;
      S_OUT: if (out_ready) begin
        if ({1'b0, vi_r} == nv - 3'd1) st_nxt = S_TRI;
        else begin
          vi_nxt = vi_r + 2'd1; st_nxt = S_EMV;
        end
      end
      S_TRI: if (out_ready) begin
        if (ti_r == nt - 3'd1) begin
          base_nxt = base_r + {16'b0, nv};
          st_nxt = S_IDLE;
        end else ti_nxt = ti_r + 3'd1;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      base_r <= '0;
      vi_r <= '0;
      ti_r <= '0;
      tri_phase_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      base_r <= base_nxt;
      vi_r <= vi_nxt;
      ti_r <= ti_nxt;
      tri_phase_r <= (st_nxt == S_TRI);
    end
    if (st_r == S_IDLE) begin
      ring_r <= {1'b0, ring};
      sec_r <= {1'b0, sector};
      cap_r <= (ring == 8'd0) || ({1'b0, ring} == cfg.height_segments - 9'd1);
      top_r <= (ring == 8'd0);
    end
  end
endmodule
`default_nettype wire

FILE: src/uv_sphere_cell_tessellator.sv
// Top level of the UV sphere cell tessellator.
`default_nettype none
// Each accepted word names one sphere cell (ring, sector) and yields the cell's vertices
// followed by its triangle indices; the final word of a cell carries last. A cap cell
// gives three vertices and one triangle, any other cell four vertices and two triangles.
// Every non-pole vertex needs two angle divisions and two CORDIC passes on one shared
// unit, plus a start step and the product steps. Each vertex word is then scaled one
// component at a time and handed over, and each index word is handed over directly. A
// new cell is accepted only while none is in progress, so the divider and the single
// CORDIC set the pace when the receiver never stalls. A cell off the grid, or any cell
// under a bad setting, is accepted and yields nothing.
// Configuration words may be written only while no cell is in progress.
module uv_sphere_cell_tessellator #(
  parameter int MAX_SEGMENTS    = 256,
  parameter int TRIG_ITERATIONS = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  uvs_in_if.sink    in_ch,
  uvs_out_if.source out_ch,
  uvs_cfg_if.sink   cfg_ch
);
  import uvs_pkg::*;

  uvs_cfg_t cfg_r;
  uvs_cmd_t cmd;
  uvs_sts_t sts;
  logic [18:0] vbase;
  logic signed [16:0] px, py, pz;
  logic signed [15:0] nx, ny, nz;
  logic [17:0] vidx;
  logic [17:0] tidx;
  logic kind;

  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.radius <= 16'd256;
      cfg_r.height_segments <= 9'd16;
      cfg_r.width_segments <= 9'd16;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_RADIUS: cfg_r.radius <= cfg_ch.data;
        REG_HEIGHT: cfg_r.height_segments <= cfg_ch.data[8:0];
        REG_WIDTH:  cfg_r.width_segments <= cfg_ch.data[8:0];
        default: ;
      endcase
    end
  end

  uvs_control #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_ctl (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .ring(in_ch.ring), .sector(in_ch.sector), .restart(in_ch.restart),
    .cmd(cmd), .sts(sts), .vbase(vbase),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .kind(kind), .last(out_ch.last), .tri_index(tidx)
  );

  uvs_datapath #(.TRIG_ITERATIONS(TRIG_ITERATIONS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r), .cmd(cmd), .vbase(vbase), .sts(sts),
    .pos_x(px), .pos_y(py), .pos_z(pz), .norm_x(nx), .norm_y(ny), .norm_z(nz),
    .vidx(vidx)
  );

  // Triangle words carry zero geometry and the vertex index from the controller's table.
  assign out_ch.kind = kind;
  assign out_ch.pos_x = kind ? '0 : px;
  assign out_ch.pos_y = kind ? '0 : py;
  assign out_ch.pos_z = kind ? '0 : pz;
  assign out_ch.norm_x = kind ? '0 : nx;
  assign out_ch.norm_y = kind ? '0 : ny;
  assign out_ch.norm_z = kind ? '0 : nz;
  assign out_ch.vertex_index = kind ? tidx : vidx;
endmodule
`default_nettype wire
